// File: rtl/rlpg_pkg.sv
// Shared types, constants and color lookups for the RGB LED pattern generator.
package rlpg_pkg;

    localparam int CMD_W     = 2;
    localparam int TIME_W    = 32;
    localparam int MODE_W    = 3;
    localparam int LEVEL_W   = 8;
    localparam int BLINK_W   = 16;
    localparam int DIVISOR_W = BLINK_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int STEP_CNT_W = 5;
    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(TIME_W - 1);

    // input commands
    localparam logic [CMD_W-1:0] CMD_SAMPLE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POWER_ON  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POWER_OFF = 2'd2;
    localparam logic [CMD_W-1:0] CMD_DEADLINE  = 2'd3;

    // pattern modes
    localparam logic [MODE_W-1:0] MODE_STEADY  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BLINK   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POLICE  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SOS     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RAINBOW = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CUSTOM  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_RED  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_GRN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_BLU  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_ON  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_OFF = 3'd5;

    // Cycle lengths folded so that a single remainder gives the phase.
    localparam logic [DIVISOR_W-1:0] BLINK_CYCLE   = 17'd2000;
    localparam logic [DIVISOR_W-1:0] POLICE_CYCLE  = 17'd800;
    localparam logic [DIVISOR_W-1:0] SOS_CYCLE     = 17'd3400;
    localparam logic [DIVISOR_W-1:0] RAINBOW_CYCLE = 17'd3500;

    localparam int SOS_IDX_W = 6;
    localparam int SOS_LEN   = 34;
    // slot 0 is the leftmost bit
    localparam logic [SOS_LEN-1:0] SOS_SLOTS = 34'b1010100011101110111000101010000000;
    // floor(x / 100) for x < 3400 is (x * 5243) >> 19
    localparam logic [12:0] SOS_RECIP = 13'd5243;

    localparam logic [23:0] RGB_BLACK = 24'h000000;
    localparam logic [23:0] RGB_RED   = 24'hFF0000;
    localparam logic [23:0] RGB_BLUE  = 24'h0000FF;
    localparam logic [23:0] RGB_WHITE = 24'hFFFFFF;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } rlpg_cmd_t;

    function automatic logic sos_lit(input logic [SOS_IDX_W-1:0] idx);
        return SOS_SLOTS[SOS_IDX_W'(SOS_LEN - 1) - idx];
    endfunction

    function automatic logic [23:0] rainbow_rgb(input logic [2:0] idx);
        logic [23:0] c;
        case (idx)
            3'd0:    c = 24'hFF0000;
            3'd1:    c = 24'hFF7F00;
            3'd2:    c = 24'hFFFF00;
            3'd3:    c = 24'h00FF00;
            3'd4:    c = 24'h00FFFF;
            3'd5:    c = 24'h0000FF;
            3'd6:    c = 24'h8B00FF;
            default: c = RGB_BLACK;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/rlpg_ctrl.sv
// Sequencer: accepts a word, runs the remainder unit, hands off to the output register.
module rlpg_ctrl
    import rlpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output rlpg_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [STEP_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  ovalid_reg, ovalid_next;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ovalid_next = ovalid_reg;
        cmd         = '0;
        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // wait for the output register to drain
                if (!ovalid_reg || out_ready)
                begin
                    cmd.finish  = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

endmodule

// File: rtl/rlpg_dp.sv
// Datapath: config registers, lamp state, bit-serial remainder unit, color select.
module rlpg_dp
    import rlpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rlpg_cmd_t             cmd,
    input  logic                  cfg_wr,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [CMD_W-1:0]      command,
    input  logic [TIME_W-1:0]     time_ms,
    input  logic [TIME_W-1:0]     deadline_ms,
    output logic [LEVEL_W-1:0]    pixel_red,
    output logic [LEVEL_W-1:0]    pixel_green,
    output logic [LEVEL_W-1:0]    pixel_blue,
    output logic                  powered
);

    logic [MODE_W-1:0]    mode_reg;
    logic [LEVEL_W-1:0]   base_r_reg, base_g_reg, base_b_reg;
    logic [BLINK_W-1:0]   on_ms_reg, off_ms_reg;
    logic                 lamp_reg, lamp_next;
    logic [TIME_W-1:0]    dl_reg, dl_next;
    logic [TIME_W-1:0]    dvd_reg;
    logic [DIVISOR_W-1:0] dvs_reg, dvs_next;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W-1:0] period;
    logic [23:0]          rgb_reg, colour;
    logic                 pow_reg;
    logic [24:0]          sos_prod;
    logic [2:0]           rb_idx;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_STEADY;
            base_r_reg <= 8'd255;
            base_g_reg <= 8'd255;
            base_b_reg <= 8'd255;
            on_ms_reg  <= 16'd500;
            off_ms_reg <= 16'd500;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_MODE:      mode_reg   <= cfg_data[MODE_W-1:0];
                CFG_BASE_RED:  base_r_reg <= cfg_data[LEVEL_W-1:0];
                CFG_BASE_GRN:  base_g_reg <= cfg_data[LEVEL_W-1:0];
                CFG_BASE_BLU:  base_b_reg <= cfg_data[LEVEL_W-1:0];
                CFG_BLINK_ON:  on_ms_reg  <= cfg_data;
                CFG_BLINK_OFF: off_ms_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign period = {1'b0, on_ms_reg} + {1'b0, off_ms_reg};

    // command first, then the auto-off check
    always_comb
    begin
        lamp_next = lamp_reg;
        dl_next   = dl_reg;
        case (command)
            CMD_POWER_ON:  lamp_next = 1'b1;
            CMD_POWER_OFF: lamp_next = 1'b0;
            CMD_DEADLINE:  dl_next   = deadline_ms;
            default:       ;
        endcase
        if ((dl_next != '0) && (time_ms >= dl_next))
        begin
            lamp_next = 1'b0;
            dl_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lamp_reg <= 1'b0;
            dl_reg   <= '0;
        end
        else if (cmd.load)
        begin
            lamp_reg <= lamp_next;
            dl_reg   <= dl_next;
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_BLINK:   dvs_next = BLINK_CYCLE;
            MODE_POLICE:  dvs_next = POLICE_CYCLE;
            MODE_SOS:     dvs_next = SOS_CYCLE;
            MODE_RAINBOW: dvs_next = RAINBOW_CYCLE;
            MODE_CUSTOM:  dvs_next = period;
            default:      dvs_next = BLINK_CYCLE;
        endcase
    end

    // restoring remainder, one dividend bit per step
    assign trial = {rem_reg, dvd_reg[TIME_W-1]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            dvd_reg <= time_ms;
            dvs_reg <= dvs_next;
            rem_reg <= '0;
        end
        else if (cmd.step)
        begin
            dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= DIVISOR_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[DIVISOR_W-1:0];
            end
        end
    end

    assign sos_prod = rem_reg[11:0] * SOS_RECIP;

    always_comb
    begin
        if (rem_reg < 17'd500)       rb_idx = 3'd0;
        else if (rem_reg < 17'd1000) rb_idx = 3'd1;
        else if (rem_reg < 17'd1500) rb_idx = 3'd2;
        else if (rem_reg < 17'd2000) rb_idx = 3'd3;
        else if (rem_reg < 17'd2500) rb_idx = 3'd4;
        else if (rem_reg < 17'd3000) rb_idx = 3'd5;
        else                         rb_idx = 3'd6;
    end

    always_comb
    begin
        colour = RGB_BLACK;
        if (lamp_reg)
        begin
            case (mode_reg)
                MODE_STEADY:
                    colour = {base_r_reg, base_g_reg, base_b_reg};
                MODE_BLINK:
                    colour = (rem_reg < 17'd1000) ? RGB_RED : RGB_BLACK;
                MODE_POLICE:
                begin
                    if (rem_reg < 17'd100)      colour = RGB_RED;
                    else if (rem_reg < 17'd150) colour = RGB_BLACK;
                    else if (rem_reg < 17'd250) colour = RGB_RED;
                    else if (rem_reg < 17'd400) colour = RGB_BLACK;
                    else if (rem_reg < 17'd500) colour = RGB_BLUE;
                    else if (rem_reg < 17'd550) colour = RGB_BLACK;
                    else if (rem_reg < 17'd650) colour = RGB_BLUE;
                    else                        colour = RGB_BLACK;
                end
                MODE_SOS:
                    colour = sos_lit(sos_prod[24:19]) ? RGB_WHITE : RGB_BLACK;
                MODE_RAINBOW:
                    colour = rainbow_rgb(rb_idx);
                MODE_CUSTOM:
                begin
                    if ((period != '0) && (rem_reg < {1'b0, on_ms_reg}))
                    begin
                        colour = {base_r_reg, base_g_reg, base_b_reg};
                    end
                end
                default:
                    colour = RGB_BLACK;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rgb_reg <= colour;
            pow_reg <= lamp_reg;
        end
    end

    assign pixel_red   = rgb_reg[23:16];
    assign pixel_green = rgb_reg[15:8];
    assign pixel_blue  = rgb_reg[7:0];
    assign powered     = pow_reg;

endmodule

// File: rtl/rgb_led_pattern_generator.sv
// RGB LED pattern generator: top level joining sequencer and datapath.
//
// Input channel (in_valid/in_ready) takes one word: command, time_ms and
// deadline_ms. The command and the auto-off check are applied when the
// word is taken; the pattern phase is then found by a bit-serial remainder
// unit that handles one timestamp bit per cycle.
// Output channel (out_valid/out_ready) returns one word per input word:
// pixel_red/green/blue and powered, held in an output register.
// The result is registered after the 32 remainder steps and the finish
// state; the finish state waits while the output register is still full.
// A new word is taken only in the idle state, after the last one is done.
// The output register frees the input side: a new word is taken while an
// earlier result waits. If the receiver still stalls when the next result
// is ready, that result waits in the finish state and input stays blocked.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always
// ready; write it only while no word is in flight.
// Reset: lamp off, no deadline, steady mode, white base color, 500/500 ms
// custom blink; no result pending.
module rgb_led_pattern_generator
    import rlpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [CMD_W-1:0]      command,
    input  logic [TIME_W-1:0]     time_ms,
    input  logic [TIME_W-1:0]     deadline_ms,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [LEVEL_W-1:0]    pixel_red,
    output logic [LEVEL_W-1:0]    pixel_green,
    output logic [LEVEL_W-1:0]    pixel_blue,
    output logic                  powered,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    rlpg_cmd_t cmd;

    assign cfg_ready = 1'b1;

    rlpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    rlpg_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .command     (command),
        .time_ms     (time_ms),
        .deadline_ms (deadline_ms),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .powered     (powered)
    );

`ifndef SYNTHESIS
    // one word at a time: input closes right after a word is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a word is in flight");

    // a dark lamp drives black
    a_off_is_black: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !powered) |->
        (pixel_red == '0 && pixel_green == '0 && pixel_blue == '0))
        else $error("unpowered result is not black");

    // a new result only comes out of the finish cycle
    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a word in flight");
`endif

endmodule
